FILE: hdl/hte_pkg.sv
`timescale 1ns / 1ps

package hte_pkg;

  localparam int FAST_BITS_DEF    = 8;
  localparam int MAX_LENGTH_DEF   = 32;
  localparam int SYMBOL_COUNT_DEF = 512;

  localparam int SYM_W    = 9;
  localparam int CLEN_W   = 5;
  localparam int WIN_W    = 32;
  localparam int LINK_W   = 10;
  localparam int LLEN_W   = 6;

  localparam logic [LINK_W-1:0] END_MARK = 10'h3FF;

  typedef enum logic [1:0] {
    K_CLEAR  = 2'd0,
    K_ADD    = 2'd1,
    K_BUILD  = 2'd2,
    K_DECODE = 2'd3
  } kind_t;

  localparam logic RK_DECODE = 1'b0;
  localparam logic RK_BUILD  = 1'b1;

  typedef struct packed {
    kind_t             kind;
    logic [SYM_W-1:0]  symbol_in;
    logic [CLEN_W-1:0] code_length_in;
    logic [WIN_W-1:0]  bit_window;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [SYM_W-1:0]  symbol_out;
    logic [CLEN_W-1:0] consumed_bits;
    logic              empty_tree;
    logic              bad_code;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_LEN,
    S_NODE,
    S_FILL,
    S_LINK,
    S_LEND,
    S_DFAST,
    S_DLIM,
    S_DSORT,
    S_RES
  } state_t;

  typedef enum logic [2:0] {
    RS_NONE,
    RS_BUILD,
    RS_FAST,
    RS_SORTED,
    RS_BAD
  } res_sel_t;

  typedef struct packed {
    logic     ready;
    logic     take;
    logic     clr_step;
    logic     len_start;
    logic     node_step;
    logic     fill_step;
    logic     link_load;
    logic     len_end;
    logic     lim_check;
    logic     load_out;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic  in_valid;
    kind_t kind;
    logic  empty;
    logic  clr_last;
    logic  node_ok;
    logic  fill_go;
    logic  fill_last;
    logic  len_last;
    logic  fast_hit;
    logic  lim_end;
    logic  lim_ge;
    logic  lim_ok;
    logic  out_free;
  } stat_t;

endpackage

FILE: hdl/hte_chan_if.sv
`timescale 1ns / 1ps

interface hte_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/hte_ctrl.sv
`timescale 1ns / 1ps

module hte_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  hte_pkg::stat_t st,
  output hte_pkg::cmd_t  cmd
);
  import hte_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (st.in_valid) begin
          unique case (st.kind) inside
            K_CLEAR, K_ADD: state_next = S_IDLE;
            K_BUILD:        state_next = S_CLR;
            K_DECODE:       state_next = st.empty ? S_RES : S_DFAST;
            default:        state_next = S_IDLE;
          endcase
        end
      end
      S_CLR:   if (st.clr_last) state_next = S_LEN;
      S_LEN:   state_next = S_NODE;
      S_NODE: begin
        if (!st.node_ok)     state_next = S_LEND;
        else if (st.fill_go) state_next = S_FILL;
        else                 state_next = S_LINK;
      end
      S_FILL:  if (st.fill_last) state_next = S_LINK;
      S_LINK:  state_next = S_NODE;
      S_LEND:  state_next = st.len_last ? S_RES : S_LEN;
      S_DFAST: state_next = st.fast_hit ? S_RES : S_DLIM;
      S_DLIM: begin
        if (st.lim_end)     state_next = S_RES;
        else if (st.lim_ge) state_next = st.lim_ok ? S_DSORT : S_RES;
      end
      S_DSORT: state_next = S_RES;
      S_RES:   if (st.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_sel = RS_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        cmd.take  = st.in_valid;
        if (st.in_valid && st.kind == K_DECODE && st.empty) cmd.res_sel = RS_BAD;
      end
      S_CLR:   cmd.clr_step  = 1'b1;
      S_LEN:   cmd.len_start = 1'b1;
      S_NODE:  cmd.node_step = st.node_ok;
      S_FILL:  cmd.fill_step = 1'b1;
      S_LINK:  cmd.link_load = 1'b1;
      S_LEND: begin
        cmd.len_end = 1'b1;
        if (st.len_last) cmd.res_sel = RS_BUILD;
      end
      S_DFAST: if (st.fast_hit) cmd.res_sel = RS_FAST;
      S_DLIM: begin
        // a matching entry whose offset underflows posts the failure directly
        cmd.lim_check = !st.lim_end && (!st.lim_ge || st.lim_ok);
        if (st.lim_end || (st.lim_ge && !st.lim_ok)) cmd.res_sel = RS_BAD;
      end
      S_DSORT: cmd.res_sel  = RS_SORTED;
      S_RES:   cmd.load_out = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hdl/hte_dp.sv
`timescale 1ns / 1ps

module hte_dp #(
  parameter int FAST_BITS    = hte_pkg::FAST_BITS_DEF,
  parameter int MAX_LENGTH   = hte_pkg::MAX_LENGTH_DEF,
  parameter int SYMBOL_COUNT = hte_pkg::SYMBOL_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  hte_pkg::cmd_t  cmd,
  output hte_pkg::stat_t st,
  hte_chan_if.sink       in_item,
  hte_chan_if.source     out_item
);
  import hte_pkg::*;

  localparam int FAST_SIZE = 1 << FAST_BITS;
  localparam int SIDX_W    = $clog2(SYMBOL_COUNT);
  localparam int LEN_W     = $clog2(MAX_LENGTH);
  localparam int FLEN_W    = $clog2(FAST_BITS + 1);
  localparam int FE_W      = 1 + FLEN_W + SYM_W;

  in_item_t in_d;
  assign in_d = in_item.data;

  // list heads and link store
  logic [LINK_W-1:0] list_head [MAX_LENGTH];
  logic [LINK_W-1:0] link_mem  [SYMBOL_COUNT];
  logic [LINK_W-1:0] link_rdata;

  // fast table: {valid, length, symbol}
  logic [FE_W-1:0]   fast_mem [FAST_SIZE];
  logic [FE_W-1:0]   fast_rdata;
  logic [SYM_W-1:0]  sorted_mem [SYMBOL_COUNT];
  logic [SYM_W-1:0]  sorted_rdata;

  logic [WIN_W-1:0]  lim_value [MAX_LENGTH];
  logic [LLEN_W-1:0] lim_len   [MAX_LENGTH];
  logic [SIDX_W-1:0] lim_off   [MAX_LENGTH];
  logic [LEN_W:0]    limit_count;
  logic              tables_empty;

  // build walk
  logic [LEN_W-1:0]     len;
  logic [WIN_W-1:0]     code;
  logic [SIDX_W:0]      offset;
  logic [LINK_W-1:0]    cur;
  logic [SIDX_W:0]      steps;
  logic                 any;
  logic [FAST_BITS-1:0] fill_ptr;
  logic [FAST_BITS:0]   fill_cnt;

  // decode
  logic [WIN_W-1:0]  win;
  logic [LEN_W:0]    li;
  logic              res_kind;
  logic [SYM_W-1:0]  res_sym;
  logic [CLEN_W-1:0] res_len;
  logic              res_bad;
  logic              out_valid;
  out_item_t         out_data;

  logic                 push_ok;
  logic                 len_fast;
  logic [4:0]           sh;
  logic                 code_small;
  logic [FAST_BITS-1:0] fill_start;
  logic [FAST_BITS:0]   fill_size;
  logic [LEN_W-1:0]     lidx;
  logic [WIN_W-1:0]     lv;
  logic [LLEN_W-1:0]    ll;
  logic [SIDX_W-1:0]    lo;
  logic [WIN_W-1:0]     diff;
  logic [WIN_W-1:0]     dval;
  logic [SIDX_W-1:0]    sorted_addr;
  logic                 out_free;

  assign push_ok = 32'(in_d.symbol_in) < SYMBOL_COUNT
                && 32'(in_d.code_length_in) < MAX_LENGTH;
  assign len_fast   = 32'(len) <= FAST_BITS;
  assign sh         = 5'(FAST_BITS) - 5'(len);
  assign code_small = (code >> len) == '0;
  assign fill_start = FAST_BITS'(code << sh);
  assign fill_size  = (FAST_BITS + 1)'(1) << sh;

  assign lidx        = li[LEN_W-1:0];
  assign lv          = lim_value[lidx];
  assign ll          = lim_len[lidx];
  assign lo          = lim_off[lidx];
  assign diff        = win - lv;
  assign dval        = diff >> (6'd32 - ll);
  assign sorted_addr = lo - dval[SIDX_W-1:0];
  assign out_free    = !out_valid || out_item.ready;

  always_comb begin
    st.in_valid  = in_item.valid;
    st.kind      = in_d.kind;
    st.empty     = tables_empty;
    st.clr_last  = fill_ptr == '1;
    st.node_ok   = 32'(cur) < SYMBOL_COUNT && 32'(steps) < SYMBOL_COUNT;
    st.fill_go   = len_fast && code_small;
    st.fill_last = fill_cnt == (FAST_BITS + 1)'(1);
    st.len_last  = 32'(len) == MAX_LENGTH - 1;
    st.fast_hit  = fast_rdata[FE_W-1];
    st.lim_end   = li == limit_count;
    st.lim_ge    = win >= lv;
    st.lim_ok    = dval <= 32'(lo);
    st.out_free  = out_free;
  end

  assign in_item.ready  = cmd.ready;
  assign out_item.valid = out_valid;
  assign out_item.data  = out_data;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LENGTH; i++) list_head[i] <= END_MARK;
      limit_count  <= '0;
      tables_empty <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.take && in_d.kind == K_CLEAR) begin
        for (int i = 0; i < MAX_LENGTH; i++) list_head[i] <= END_MARK;
      end
      if (cmd.take && in_d.kind == K_ADD && push_ok) begin
        list_head[LEN_W'(in_d.code_length_in)] <= LINK_W'(in_d.symbol_in);
      end
      if (cmd.take && in_d.kind == K_BUILD) begin
        limit_count  <= '0;
        tables_empty <= 1'b1;
      end
      if (cmd.len_end && any) begin
        tables_empty <= 1'b0;
        if (!len_fast && 32'(limit_count) < MAX_LENGTH) limit_count <= limit_count + 1'b1;
      end
      if (cmd.load_out)       out_valid <= 1'b1;
      else if (out_item.ready) out_valid <= 1'b0;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (cmd.take && in_d.kind == K_BUILD) begin
      code     <= '0;
      offset   <= '0;
      len      <= '0;
      fill_ptr <= '0;
    end
    if (cmd.take && in_d.kind == K_DECODE) begin
      win <= in_d.bit_window;
      li  <= '0;
    end
    if (cmd.clr_step) fill_ptr <= fill_ptr + 1'b1;
    if (cmd.len_start) begin
      cur   <= list_head[len];
      steps <= '0;
      any   <= 1'b0;
    end
    if (cmd.node_step) begin
      any   <= 1'b1;
      code  <= code - 1'b1;
      steps <= steps + 1'b1;
      if (len_fast) begin
        if (code_small) begin
          fill_ptr <= fill_start;
          fill_cnt <= fill_size;
        end
      end else if (32'(offset) < SYMBOL_COUNT) begin
        offset <= offset + 1'b1;
      end
    end
    if (cmd.fill_step) begin
      fill_ptr <= fill_ptr + 1'b1;
      fill_cnt <= fill_cnt - 1'b1;
    end
    if (cmd.link_load) cur <= link_rdata;
    if (cmd.len_end) begin
      code <= (code << 1) + 1'b1;
      len  <= len + 1'b1;
      if (any && !len_fast && 32'(limit_count) < MAX_LENGTH) begin
        lim_value[limit_count[LEN_W-1:0]] <= (code + 1'b1) << (6'd32 - 6'(len));
        lim_len[limit_count[LEN_W-1:0]]   <= 6'(len);
        lim_off[limit_count[LEN_W-1:0]]   <= SIDX_W'(offset - 1'b1);
      end
    end
    if (cmd.lim_check) begin
      res_len <= ll[CLEN_W-1:0];
      if (!st.lim_ge) li <= li + 1'b1;
    end
    case (cmd.res_sel)
      RS_BUILD: begin
        res_kind <= RK_BUILD;
        res_sym  <= '0;
        res_len  <= '0;
        res_bad  <= 1'b0;
      end
      RS_FAST: begin
        res_kind <= RK_DECODE;
        res_sym  <= fast_rdata[SYM_W-1:0];
        res_len  <= CLEN_W'(fast_rdata[SYM_W +: FLEN_W]);
        res_bad  <= 1'b0;
      end
      RS_SORTED: begin
        res_kind <= RK_DECODE;
        res_sym  <= sorted_rdata;
        res_bad  <= 1'b0;
      end
      RS_BAD: begin
        res_kind <= RK_DECODE;
        res_sym  <= '0;
        res_len  <= '0;
        res_bad  <= 1'b1;
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      out_data.result_kind   <= res_kind;
      out_data.symbol_out    <= res_sym;
      out_data.consumed_bits <= res_len;
      out_data.empty_tree    <= tables_empty;
      out_data.bad_code      <= res_bad;
    end
  end

  // link store
  always_ff @(posedge clk) begin
    if (cmd.take && in_d.kind == K_ADD && push_ok) begin
      link_mem[SIDX_W'(in_d.symbol_in)] <= list_head[LEN_W'(in_d.code_length_in)];
    end
    if (cmd.node_step) link_rdata <= link_mem[cur[SIDX_W-1:0]];
  end

  // fast table
  always_ff @(posedge clk) begin
    if (cmd.clr_step) fast_mem[fill_ptr] <= '0;
    else if (cmd.fill_step) fast_mem[fill_ptr] <= {1'b1, FLEN_W'(len), SYM_W'(cur)};
    if (cmd.take) fast_rdata <= fast_mem[in_d.bit_window[WIN_W-1 -: FAST_BITS]];
  end

  // sorted symbols of the long lengths
  always_ff @(posedge clk) begin
    if (cmd.node_step && !len_fast && 32'(offset) < SYMBOL_COUNT) begin
      sorted_mem[offset[SIDX_W-1:0]] <= SYM_W'(cur);
    end
    if (cmd.lim_check) sorted_rdata <= sorted_mem[sorted_addr];
  end

  a_fill_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_step |-> fill_cnt != '0)
    else $error("fast fill step with empty count");

  a_lim_idx: assert property (@(posedge clk) disable iff (rst)
    cmd.lim_check |-> li < limit_count)
    else $error("limit search beyond used entries");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_item.ready))
    else $error("result loaded over a pending transaction");

endmodule

FILE: hdl/huffman_table_build_and_decode.sv
`timescale 1ns / 1ps

// Canonical Huffman decoder with tables built in place. Each input transaction
// carries a kind: clear lists (no result), add symbol (no result), build
// tables or decode a 32-bit MSB-first window (one result each). A build
// clears the fast table entry by entry, then per code length walks the listed
// symbols and fills 2^(FAST_BITS-len) fast-table entries for each short
// symbol whose code fits, then posts the result. A decode looks up the fast
// table; on a miss it scans the limit entries in order and then reads the
// sorted symbols. Only one transaction is in flight; a result waits in the
// output register and the block goes idle again once it is free. bad_code
// flags an empty tree or an unmatched window; consumed_bits gives the length
// to drop from the stream.
module huffman_table_build_and_decode #(
  parameter int FAST_BITS    = hte_pkg::FAST_BITS_DEF,
  parameter int MAX_LENGTH   = hte_pkg::MAX_LENGTH_DEF,
  parameter int SYMBOL_COUNT = hte_pkg::SYMBOL_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  hte_chan_if.sink   in_item,
  hte_chan_if.source out_item
);
  import hte_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer: walks lists, fill ranges and the limit scan
  hte_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  // tables, memories, walk counters and the output register
  hte_dp #(
    .FAST_BITS    (FAST_BITS),
    .MAX_LENGTH   (MAX_LENGTH),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hte_pkg::*;

  localparam int FAST_BITS    = FAST_BITS_DEF;
  localparam int MAX_LENGTH   = MAX_LENGTH_DEF;
  localparam int SYMBOL_COUNT = SYMBOL_COUNT_DEF;
  localparam int FAST_SIZE    = 1 << FAST_BITS;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RANDOM_ITEMS = 1950;

  // Mirror of the decoder tables plus the queue of results still owed.
  class huff_scoreboard;
    logic [LINK_W-1:0] list_head [MAX_LENGTH];
    logic [LINK_W-1:0] next_link [SYMBOL_COUNT];
    logic [SYM_W-1:0]  fast_sym  [FAST_SIZE];
    bit                fast_ok   [FAST_SIZE];
    logic [CLEN_W-1:0] fast_len  [FAST_SIZE];
    logic [31:0]       lim_val   [MAX_LENGTH];
    int unsigned       lim_len   [MAX_LENGTH];
    int unsigned       lim_off   [MAX_LENGTH];
    int unsigned       lim_cnt;
    logic [SYM_W-1:0]  sorted    [SYMBOL_COUNT];
    bit                tables_empty;
    out_item_t         owed_q[$];
    int                errors;

    function new();
      foreach (list_head[i]) list_head[i] = END_MARK;
      foreach (next_link[i]) next_link[i] = '0;
      wipe_tables();
      errors = 0;
    endfunction

    function void wipe_tables();
      foreach (fast_sym[i]) begin
        fast_sym[i] = '0;
        fast_ok[i]  = 1'b0;
        fast_len[i] = '0;
      end
      foreach (lim_val[i]) begin
        lim_val[i] = '0;
        lim_len[i] = 0;
        lim_off[i] = 0;
      end
      foreach (sorted[i]) sorted[i] = '0;
      lim_cnt      = 0;
      tables_empty = 1'b1;
    endfunction

    // Canonical build: codes count down from all-ones within each length.
    function void build_tables();
      logic [31:0] code;
      logic [31:0] start_i, stop_i;
      int unsigned offset, cur, steps;
      bit any;
      code   = 0;
      offset = 0;
      wipe_tables();
      for (int len = 0; len < MAX_LENGTH; len++) begin
        cur   = list_head[len];
        steps = 0;
        any   = 1'b0;
        while (cur < SYMBOL_COUNT && steps < SYMBOL_COUNT) begin
          any = 1'b1;
          if (len <= FAST_BITS) begin
            // an overfull set leaves codes that no longer fit: no fast entry
            if (code < (32'd1 << len)) begin
              start_i = code << (FAST_BITS - len);
              stop_i  = (code + 32'd1) << (FAST_BITS - len);
              for (logic [31:0] i = start_i; i < stop_i && i < FAST_SIZE; i++) begin
                fast_sym[i] = cur[SYM_W-1:0];
                fast_ok[i]  = 1'b1;
                fast_len[i] = len[CLEN_W-1:0];
              end
            end
          end else if (offset < SYMBOL_COUNT) begin
            sorted[offset] = cur[SYM_W-1:0];
            offset++;
          end
          code  = code - 32'd1;
          cur   = next_link[cur];
          steps++;
        end
        if (any) begin
          tables_empty = 1'b0;
          if (len > FAST_BITS && lim_cnt < MAX_LENGTH) begin
            lim_val[lim_cnt] = (code + 32'd1) << (32 - len);
            lim_len[lim_cnt] = len;
            lim_off[lim_cnt] = (offset - 1) & 32'h1FF;
            lim_cnt++;
          end
        end
        code = (code << 1) + 32'd1;
      end
    endfunction

    function out_item_t decode_window(logic [31:0] win);
      out_item_t r;
      logic [31:0] d;
      int unsigned idx;
      r = '0;
      r.result_kind = RK_DECODE;
      r.empty_tree  = tables_empty;
      if (tables_empty) begin
        r.bad_code = 1'b1;
        return r;
      end
      idx = win >> (32 - FAST_BITS);
      if (fast_ok[idx]) begin
        r.symbol_out    = fast_sym[idx];
        r.consumed_bits = fast_len[idx];
        return r;
      end
      r.bad_code = 1'b1;
      for (int unsigned i = 0; i < lim_cnt; i++) begin
        if (win >= lim_val[i]) begin
          d = (win - lim_val[i]) >> (32 - lim_len[i]);
          if (d <= lim_off[i] && lim_off[i] - d < SYMBOL_COUNT) begin
            r.symbol_out    = sorted[lim_off[i] - d];
            r.consumed_bits = lim_len[i][CLEN_W-1:0];
            r.bad_code      = 1'b0;
          end
          break;
        end
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      case (it.kind)
        K_CLEAR: foreach (list_head[i]) list_head[i] = END_MARK;
        K_ADD: begin
          next_link[it.symbol_in]      = list_head[it.code_length_in];
          list_head[it.code_length_in] = {1'b0, it.symbol_in};
        end
        K_BUILD: begin
          build_tables();
          r = '0;
          r.result_kind = RK_BUILD;
          r.empty_tree  = tables_empty;
          owed_q.push_back(r);
        end
        default: owed_q.push_back(decode_window(it.bit_window));
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (owed_q.size() == 0) begin
        $error("unexpected result transaction %h", got);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      if (got.result_kind !== exp.result_kind) begin
        $error("result_kind exp %0d got %0d", exp.result_kind, got.result_kind);
        errors++;
      end
      if (got.symbol_out !== exp.symbol_out) begin
        $error("symbol_out exp %0d got %0d", exp.symbol_out, got.symbol_out);
        errors++;
      end
      if (got.consumed_bits !== exp.consumed_bits) begin
        $error("consumed_bits exp %0d got %0d", exp.consumed_bits, got.consumed_bits);
        errors++;
      end
      if (got.empty_tree !== exp.empty_tree) begin
        $error("empty_tree exp %0d got %0d", exp.empty_tree, got.empty_tree);
        errors++;
      end
      if (got.bad_code !== exp.bad_code) begin
        $error("bad_code exp %0d got %0d", exp.bad_code, got.bad_code);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  hte_chan_if #(.T(in_item_t))  in_ch ();
  hte_chan_if #(.T(out_item_t)) out_ch ();

  huffman_table_build_and_decode i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  huff_scoreboard sb = new();

  // Idle rates (percent) for the two sides, switched by the stimulus phases.
  int tx_idle_pct = 23;
  int rx_idle_pct = 56;
  // A bump of hold_req asks the receiver for one long hold-off.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: a hung block must still end the run with a verdict.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus the long hold-off on request so the
  // single-entry output register fills and the block stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Both monitors sample at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // One input transaction; valid stays high into the next call unless a gap
  // is drawn, so it is never dropped and raised within one step.
  task automatic send(kind_t k, logic [SYM_W-1:0] s, logic [CLEN_W-1:0] l,
                      logic [WIN_W-1:0] w);
    in_item_t it;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    it.kind           = k;
    it.symbol_in      = s;
    it.code_length_in = l;
    it.bit_window     = w;
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  function automatic logic [SYM_W-1:0] rnd_sym();
    return SYM_W'($urandom_range(511));
  endfunction

  function automatic logic [CLEN_W-1:0] rnd_len();
    return CLEN_W'($urandom_range(31));
  endfunction

  task automatic add_sym(int s, int l);
    send(K_ADD, s[SYM_W-1:0], l[CLEN_W-1:0], $urandom());
  endtask

  task automatic decode(logic [31:0] w);
    send(K_DECODE, rnd_sym(), rnd_len(), w);
  endtask

  // Windows: plain random, or shifted down so long codes (low values) are hit.
  function automatic logic [31:0] pick_window();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom() >> $urandom_range(31);
      2: return $urandom() >> $urandom_range(8, 20);
      default: return {8'($urandom_range(255)), 24'h0} | ($urandom() >> $urandom_range(8, 31));
    endcase
  endfunction

  // Sender pause: nothing more is offered until every result is back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_q.size() != 0) @(posedge clk);
  endtask

  // A code set that respects the Kraft sum: free slots double per length and
  // each length takes some of them, with distinct symbols. Then decodes.
  task automatic good_set();
    longint slots;
    int k, nsym, base;
    slots = 1;
    nsym  = 0;
    base  = $urandom_range(511);
    send(K_CLEAR, rnd_sym(), rnd_len(), $urandom());
    for (int l = 1; l < MAX_LENGTH && slots > 0 && nsym < 60; l++) begin
      slots = (slots * 2 > 64'h1_0000_0000) ? 64'h1_0000_0000 : slots * 2;
      k = $urandom_range(0, (slots < 5) ? int'(slots) : 5);
      if ($urandom_range(7) == 0) k = 0;
      for (int j = 0; j < k; j++) begin
        add_sym((base + nsym) % SYMBOL_COUNT, l);
        nsym++;
      end
      slots -= k;
    end
    send(K_BUILD, rnd_sym(), rnd_len(), $urandom());
    repeat ($urandom_range(15, 40)) decode(pick_window());
  endtask

  // Noise: random pushes of any symbol and length, duplicates and loops
  // included, sometimes stacked on top of stale lists.
  task automatic noisy_set();
    if ($urandom_range(3) != 0)
      send(K_CLEAR, rnd_sym(), rnd_len(), $urandom());
    repeat ($urandom_range(0, 12)) add_sym($urandom_range(511), $urandom_range(31));
    send(K_BUILD, rnd_sym(), rnd_len(), $urandom());
    repeat ($urandom_range(5, 20)) decode(pick_window());
  endtask

  initial begin
    int start_cnt;
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: decode before any build sees the empty tree.
    decode(32'hFFFF_FFFF);
    send(K_BUILD, 9'h1FF, 5'h1F, 32'h0);
    decode(32'h0);
    // A length-zero symbol covers the whole fast table.
    add_sym(511, 0);
    send(K_BUILD, '0, '0, 32'hFFFF_FFFF);
    decode(32'h1234_5678);
    // Extreme symbols and lengths, both sides of the fast boundary.
    send(K_CLEAR, 9'h1FF, 5'h1F, 32'hFFFF_FFFF);
    add_sym(0, 1);
    add_sym(511, 8);
    add_sym(17, 9);
    add_sym(300, 31);
    add_sym(301, 31);
    send(K_BUILD, '0, '0, 32'h0);
    decode(32'hFFFF_FFFF);
    decode(32'h0);
    decode(32'h7F80_0000);
    decode(32'h7F00_0000);
    decode(32'h0000_0001);
    // Clearing the lists leaves the built tables intact.
    send(K_CLEAR, '0, '0, 32'h0);
    decode(32'hFF00_0000);
    // Overfull set: three codes of length one.
    add_sym(5, 1);
    add_sym(6, 1);
    add_sym(7, 1);
    send(K_BUILD, '0, '0, 32'h0);
    decode(32'h8000_0000);
    decode(32'h0);

    // Random part in three idling phases.
    start_cnt = sent;
    while (sent - start_cnt < RANDOM_ITEMS) begin
      if (sent - start_cnt >= 650 && tx_idle_pct == 23) begin
        tx_idle_pct = 56;
        rx_idle_pct = 23;
        hold_req++;
      end else if (sent - start_cnt >= 1300 && tx_idle_pct == 56) begin
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if ($urandom_range(4) == 0) noisy_set();
      else good_set();
    end

    in_ch.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
